// ----- hw/rtl/bmfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmfd_pkg: shared types and constants
// Request codes, payload structs and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package bmfd_pkg;

  // Request codes
  localparam logic [1:0] REQ_INIT    = 2'd0;
  localparam logic [1:0] REQ_SEGMENT = 2'd1;
  localparam logic [1:0] REQ_UPDATE  = 2'd2;

  // Reset value of the match threshold
  localparam logic [7:0] THR_RESET = 8'd10;

  // Write address selects
  localparam logic [1:0] WSEL_SEQ = 2'd0;
  localparam logic [1:0] WSEL_PIX = 2'd1;
  localparam logic [1:0] WSEL_NBR = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] pixel_index;
    logic [7:0]  pixel_value;
    logic [4:0]  sample_slot;
    logic [11:0] neighbor_index;
    logic        write_neighbor;
  } req_t;

  typedef struct packed {
    logic       foreground;
    logic [7:0] mean_value;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;   // latch request, reset accumulators
    logic       step;   // advance sequential address by one frame
    logic       rd;     // read history at sequential address
    logic       wr;     // write pixel value into history
    logic [1:0] wsel;   // write address select
    logic       div;    // scale the sum into the mean
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pix_ok;
    logic nbr_ok;
    logic slot_ok;
    logic wr_nbr;
  } sts_t;

endpackage

// ----- hw/rtl/bmfd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmfd_ctrl: request sequencer
// Steps init writes, update writes, segment reads and the mean scaling, and
// raises the one-cycle result strobe.
// ----------------------------------------------------------------------------
module bmfd_ctrl #(
  parameter int unsigned SAMPLES = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        req_type_i,
  input  bmfd_pkg::sts_t    sts_i,
  output bmfd_pkg::cmd_t    cmd_o,
  output logic              busy,
  output logic              done_o
);

  localparam int unsigned CNT_W = ($clog2(SAMPLES) > 3) ? $clog2(SAMPLES) : 3;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INIT     = 3'd1;
  localparam logic [2:0] S_UPD_P    = 3'd2;
  localparam logic [2:0] S_UPD_N    = 3'd3;
  localparam logic [2:0] S_SEG_RD   = 3'd4;
  localparam logic [2:0] S_SEG_LAST = 3'd5;
  localparam logic [2:0] S_DIV      = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last_smp;

  assign last_smp = (cnt_q == CNT_W'(SAMPLES - 1));

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.wsel = bmfd_pkg::WSEL_SEQ;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (start) begin
          cmd_o.load = 1'b1;
          case (req_type_i)
            bmfd_pkg::REQ_INIT:    state_d = S_INIT;
            bmfd_pkg::REQ_SEGMENT: state_d = S_SEG_RD;
            bmfd_pkg::REQ_UPDATE:  state_d = S_UPD_P;
            default:               state_d = S_IDLE;
          endcase
        end
      end
      S_INIT: begin
        cmd_o.wr   = sts_i.pix_ok;
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (last_smp) begin
          state_d = S_IDLE;
        end
      end
      S_UPD_P: begin
        cmd_o.wr   = sts_i.pix_ok && sts_i.slot_ok;
        cmd_o.wsel = bmfd_pkg::WSEL_PIX;
        state_d    = sts_i.wr_nbr ? S_UPD_N : S_IDLE;
      end
      S_UPD_N: begin
        cmd_o.wr   = sts_i.nbr_ok && sts_i.slot_ok;
        cmd_o.wsel = bmfd_pkg::WSEL_NBR;
        state_d    = S_IDLE;
      end
      S_SEG_RD: begin
        if (!sts_i.pix_ok) begin
          // out of frame: answer zero at once
          state_d = S_DONE;
        end else begin
          cmd_o.rd   = 1'b1;
          cmd_o.step = 1'b1;
          cnt_d      = cnt_q + 1'b1;
          if (last_smp) begin
            state_d = S_SEG_LAST;
          end
        end
      end
      S_SEG_LAST: begin
        // drain the last read into the sum
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

// ----- hw/rtl/bmfd_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmfd_dpath: history memory and arithmetic
// Holds the sample history, accumulates a pixel's samples, scales the sum
// down by the sample count and compares against the pixel value.
// ----------------------------------------------------------------------------
module bmfd_dpath #(
  parameter int unsigned SAMPLES      = 25,
  parameter int unsigned FRAME_PIXELS = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bmfd_pkg::req_t request_i,
  input  bmfd_pkg::cmd_t cmd_i,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  output bmfd_pkg::sts_t sts_o,
  output bmfd_pkg::res_t result_o
);

  localparam int unsigned DEPTH  = SAMPLES * FRAME_PIXELS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SUM_W  = $clog2(SAMPLES * 255 + 1);
  localparam logic [ADDR_W-1:0] FP_A = ADDR_W'(FRAME_PIXELS);
  // Reciprocal of the sample count, rounded up; its error stays below one
  // quotient step for every sum that fits SUM_W bits
  localparam int unsigned REC_SH = SUM_W + $clog2(SAMPLES);
  localparam int unsigned REC_W  = SUM_W + 2;
  localparam int unsigned PROD_W = SUM_W + REC_W;
  localparam logic [REC_W-1:0] RECIP = REC_W'((2 ** REC_SH + SAMPLES - 1) / SAMPLES);

  logic [7:0]        mem_q [DEPTH];
  bmfd_pkg::req_t    req_q;
  logic [7:0]        thr_q;
  logic [ADDR_W-1:0] addr_q;
  logic [7:0]        rdata_q;
  logic              rd_vld_q;
  logic [SUM_W-1:0]  sum_q;
  logic [7:0]        quo_q;
  logic [ADDR_W-1:0] slot_base, waddr;
  logic [PROD_W-1:0] prod;
  logic [8:0]        lim;

  // Range checks on the latched request
  assign sts_o.pix_ok  = (32'(req_q.pixel_index) < 32'(FRAME_PIXELS));
  assign sts_o.nbr_ok  = (32'(req_q.neighbor_index) < 32'(FRAME_PIXELS));
  assign sts_o.slot_ok = (6'(req_q.sample_slot) < 6'(SAMPLES));
  assign sts_o.wr_nbr  = req_q.write_neighbor;

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= bmfd_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Latch request and walk the sequential address
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= request_i;
      addr_q <= ADDR_W'(request_i.pixel_index);
    end else if (cmd_i.step) begin
      addr_q <= addr_q + FP_A;
    end
  end

  // Select write address
  assign slot_base = ADDR_W'(ADDR_W'(req_q.sample_slot) * FP_A);
  always_comb begin
    case (cmd_i.wsel)
      bmfd_pkg::WSEL_PIX: waddr = slot_base + ADDR_W'(req_q.pixel_index);
      bmfd_pkg::WSEL_NBR: waddr = slot_base + ADDR_W'(req_q.neighbor_index);
      default:            waddr = addr_q;
    endcase
  end

  // History memory write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[waddr] <= req_q.pixel_value;
    end
  end

  // History memory read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rdata_q <= mem_q[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd;
    end
  end

  // Accumulate samples, then take the mean as sum times reciprocal
  assign prod = PROD_W'(sum_q) * PROD_W'(RECIP);
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sum_q <= '0;
      quo_q <= '0;
    end else if (rd_vld_q) begin
      sum_q <= sum_q + SUM_W'(rdata_q);
    end else if (cmd_i.div) begin
      quo_q <= prod[REC_SH +: 8];
    end
  end

  // Compare pixel against mean plus margin
  assign lim                 = {1'b0, quo_q} + {1'b0, thr_q};
  assign result_o.mean_value = quo_q;
  assign result_o.foreground = sts_o.pix_ok && (lim < {1'b0, req_q.pixel_value});

endmodule

// ----- hw/rtl/background_mean_foreground_detect_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// background_mean_foreground_detect_top: per-pixel background mean detector
// Init fills all sample slots of a pixel, update overwrites one slot of a
// pixel and optionally a neighbor, segment returns mean and foreground flag.
// ----------------------------------------------------------------------------
// Segment: one history read per cycle from the single read port, then a drain step,
//   the reciprocal multiply and the result strobe; out-of-frame pixels go straight
//   to the strobe. One request at a time, and busy is high until the next can be
//   taken; the receiver cannot stall.
// Reset clears control state and sets the threshold to 10; history is not cleared.
module background_mean_foreground_detect_top #(
  parameter int unsigned SAMPLES      = 25,
  parameter int unsigned FRAME_PIXELS = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bmfd_pkg::req_t request_i,
  output logic           result_valid_o,
  output bmfd_pkg::res_t result_o,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i
);

  bmfd_pkg::cmd_t cmd;
  bmfd_pkg::sts_t sts;

  // Sequencer
  bmfd_ctrl #(
    .SAMPLES (SAMPLES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (request_i.req_type),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy       (busy),
    .done_o     (result_valid_o)
  );

  // Memory and arithmetic
  bmfd_dpath #(
    .SAMPLES      (SAMPLES),
    .FRAME_PIXELS (FRAME_PIXELS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .request_i   (request_i),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_o       (sts),
    .result_o    (result_o)
  );

  // Result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  // A segment request always makes the block busy
  a_seg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && request_i.req_type == bmfd_pkg::REQ_SEGMENT) |=> busy)
    else $error("segment request not taken");

  // History is written and read only while a request is in flight
  a_mem_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.wr || cmd.rd) |-> busy)
    else $error("history access while idle");

  // Never read and write the history in the same cycle
  a_rd_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.wr && cmd.rd))
    else $error("history read and write together");

endmodule
